// ===== design/tst_pkg.sv =====
// shared constants and types for the two-stage trie store
`timescale 1ns / 1ps
package tst_pkg;

	localparam int BLOCK_SHIFT  = 5;
	localparam int POOL_WORDS   = 65536;

	localparam int CP_W         = 21;
	localparam int VAL_W        = 32;
	localparam int BLOCK_WORDS  = 1 << BLOCK_SHIFT;
	localparam int CODE_SPAN    = 32'h0011_0000;
	localparam int STAGE1_DEPTH = CODE_SPAN >> BLOCK_SHIFT;
	localparam int S1_AW        = $clog2(STAGE1_DEPTH);
	localparam int SLOT_W       = CP_W - BLOCK_SHIFT;
	localparam int PW_AW        = $clog2(POOL_WORDS);
	localparam int NF_W         = PW_AW + 1;

	localparam logic [CP_W-1:0]  CODE_LIMIT = CP_W'(CODE_SPAN);
	localparam logic [VAL_W-1:0] FILL_WORD  = 32'hF000_0000;

	// source of the result word
	typedef enum logic [1:0] {
		RES_ZERO = 2'd0,
		RES_FILL = 2'd1,
		RES_FULL = 2'd2,
		RES_POOL = 2'd3
	} res_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     clr_we;
		logic     acc;
		logic     s1_alloc;
		logic     pool_rd;
		logic     pool_wr;
		logic     fill_we;
		logic     res_we;
		res_sel_t res_sel;
		logic     out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic act_write;
		logic in_range;
		logic start_zero;
		logic pool_avail;
		logic clr_last;
		logic fill_last;
	} sts_t;

endpackage

// ===== design/tst_req_if.sv =====
// request channel of the trie store
`timescale 1ns / 1ps
interface tst_req_if;
	logic                           valid;
	logic                           ready;
	logic                           action;
	logic [tst_pkg::CP_W-1:0]       code_point;
	logic signed [tst_pkg::VAL_W-1:0] write_value;

	modport source (output valid, output action, output code_point, output write_value,
		input ready);
	modport sink (input valid, input action, input code_point, input write_value,
		output ready);
endinterface

// ===== design/tst_rsp_if.sv =====
// response channel of the trie store
`timescale 1ns / 1ps
interface tst_rsp_if;
	logic                             valid;
	logic                             ready;
	logic signed [tst_pkg::VAL_W-1:0] read_value;
	logic                             pool_full;

	modport source (output valid, output read_value, output pool_full, input ready);
	modport sink (input valid, input read_value, input pool_full, output ready);
endinterface

// ===== design/tst_datapath.sv =====
// trie store datapath: stage-1 table, value pool, counters and result registers
`timescale 1ns / 1ps
module tst_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tst_pkg::cmd_t                    cmd,
	output tst_pkg::sts_t                    sts,
	input  logic                             req_action,
	input  logic [tst_pkg::CP_W-1:0]         req_code_point,
	input  logic signed [tst_pkg::VAL_W-1:0] req_write_value,
	output logic signed [tst_pkg::VAL_W-1:0] rsp_read_value,
	output logic                             rsp_pool_full
);

	logic [tst_pkg::S1_AW-1:0]   clr_cnt_q;
	logic [tst_pkg::BLOCK_SHIFT-1:0] fill_cnt_q;
	logic [tst_pkg::NF_W-1:0]    nf_q;
	logic [tst_pkg::NF_W:0]      nf_sum;

	logic                        act_q;
	logic [tst_pkg::CP_W-1:0]    cp_q;
	logic [tst_pkg::VAL_W-1:0]   val_q;

	logic [tst_pkg::SLOT_W-1:0]  in_slot_full;
	logic [tst_pkg::S1_AW-1:0]   in_slot;
	logic [tst_pkg::SLOT_W-1:0]  slot_full;
	logic [tst_pkg::S1_AW-1:0]   slot;
	logic [tst_pkg::BLOCK_SHIFT-1:0] low;

	logic [tst_pkg::PW_AW-1:0]   s1_mem [tst_pkg::STAGE1_DEPTH];
	logic [tst_pkg::PW_AW-1:0]   s1_rd_q;

	logic [tst_pkg::VAL_W-1:0]   pool_mem [tst_pkg::POOL_WORDS];
	logic [tst_pkg::VAL_W-1:0]   pool_rd_q;
	logic [tst_pkg::PW_AW-1:0]   word_addr;
	logic [tst_pkg::PW_AW-1:0]   wr_addr;
	logic [tst_pkg::VAL_W-1:0]   wr_data;

	logic [tst_pkg::VAL_W-1:0]   res_value_q;
	logic                        res_full_q;
	logic [tst_pkg::VAL_W-1:0]   out_value_q;
	logic                        out_full_q;

	// slot of the incoming code point, forced to entry 0 when out of range
	assign in_slot_full = req_code_point[tst_pkg::CP_W-1:tst_pkg::BLOCK_SHIFT];
	assign in_slot      = (req_code_point < tst_pkg::CODE_LIMIT) ?
		in_slot_full[tst_pkg::S1_AW-1:0] : '0;

	assign slot_full = cp_q[tst_pkg::CP_W-1:tst_pkg::BLOCK_SHIFT];
	assign slot      = slot_full[tst_pkg::S1_AW-1:0];
	assign low       = cp_q[tst_pkg::BLOCK_SHIFT-1:0];

	assign nf_sum = {1'b0, nf_q} + (tst_pkg::NF_W + 1)'(tst_pkg::BLOCK_WORDS);

	assign word_addr = s1_rd_q + tst_pkg::PW_AW'(low);
	assign wr_addr   = cmd.fill_we ? (nf_q[tst_pkg::PW_AW-1:0] + tst_pkg::PW_AW'(fill_cnt_q))
		: word_addr;
	assign wr_data   = (cmd.fill_we && (fill_cnt_q != low)) ? tst_pkg::FILL_WORD : val_q;

	assign sts.act_write  = act_q;
	assign sts.in_range   = cp_q < tst_pkg::CODE_LIMIT;
	assign sts.start_zero = s1_rd_q == '0;
	assign sts.pool_avail = nf_sum <= (tst_pkg::NF_W + 1)'(tst_pkg::POOL_WORDS);
	assign sts.clr_last   = clr_cnt_q == tst_pkg::S1_AW'(tst_pkg::STAGE1_DEPTH - 1);
	assign sts.fill_last  = &fill_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			fill_cnt_q <= '0;
			nf_q       <= tst_pkg::NF_W'(tst_pkg::BLOCK_WORDS);
		end else begin
			if (cmd.clr_we) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.fill_we) begin
				fill_cnt_q <= fill_cnt_q + 1'b1;
				if (&fill_cnt_q) begin
					nf_q <= nf_sum[tst_pkg::NF_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			act_q <= req_action;
			cp_q  <= req_code_point;
			val_q <= req_write_value;
		end
	end

	// stage-1 table, one port
	always_ff @(posedge clk) begin
		if (cmd.clr_we) begin
			s1_mem[clr_cnt_q] <= '0;
		end else if (cmd.s1_alloc) begin
			s1_mem[slot] <= nf_q[tst_pkg::PW_AW-1:0];
		end else if (cmd.acc) begin
			s1_rd_q <= s1_mem[in_slot];
		end
	end

	// value pool, one port
	always_ff @(posedge clk) begin
		if (cmd.pool_wr || cmd.fill_we) begin
			pool_mem[wr_addr] <= wr_data;
		end else if (cmd.pool_rd) begin
			pool_rd_q <= pool_mem[word_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_we) begin
			case (cmd.res_sel)
				tst_pkg::RES_FILL: begin
					res_value_q <= tst_pkg::FILL_WORD;
					res_full_q  <= 1'b0;
				end
				tst_pkg::RES_FULL: begin
					res_value_q <= '0;
					res_full_q  <= 1'b1;
				end
				tst_pkg::RES_POOL: begin
					res_value_q <= pool_rd_q;
					res_full_q  <= 1'b0;
				end
				default: begin
					res_value_q <= '0;
					res_full_q  <= 1'b0;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_value_q <= res_value_q;
			out_full_q  <= res_full_q;
		end
	end

	assign rsp_read_value = $signed(out_value_q);
	assign rsp_pool_full  = out_full_q;

endmodule

// ===== design/tst_ctrl.sv =====
// trie store controller state machine
`timescale 1ns / 1ps
module tst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  tst_pkg::sts_t sts,
	output tst_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_LOOK  = 6'b000100,
		ST_PREAD = 6'b001000,
		ST_FILL  = 6'b010000,
		ST_HOLD  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.res_sel = tst_pkg::RES_ZERO;
		req_ready   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.acc = 1'b1;
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (!sts.act_write) begin
					if (sts.in_range && !sts.start_zero) begin
						cmd.pool_rd = 1'b1;
						state_d     = ST_PREAD;
					end else begin
						cmd.res_we  = 1'b1;
						cmd.res_sel = tst_pkg::RES_FILL;
						state_d     = ST_HOLD;
					end
				end else if (!sts.in_range) begin
					cmd.res_we = 1'b1;
					state_d    = ST_HOLD;
				end else if (!sts.start_zero) begin
					cmd.pool_wr = 1'b1;
					cmd.res_we  = 1'b1;
					state_d     = ST_HOLD;
				end else if (sts.pool_avail) begin
					cmd.s1_alloc = 1'b1;
					state_d      = ST_FILL;
				end else begin
					cmd.res_we  = 1'b1;
					cmd.res_sel = tst_pkg::RES_FULL;
					state_d     = ST_HOLD;
				end
			end
			ST_PREAD: begin
				cmd.res_we  = 1'b1;
				cmd.res_sel = tst_pkg::RES_POOL;
				state_d     = ST_HOLD;
			end
			ST_FILL: begin
				cmd.fill_we = 1'b1;
				if (sts.fill_last) begin
					cmd.res_we = 1'b1;
					state_d    = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					req_ready    = 1'b1;
					if (req_valid) begin
						cmd.acc = 1'b1;
						state_d = ST_LOOK;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/two_stage_trie_store_core.sv =====
// two-stage trie store: code point to 32-bit value map, top level
// a stored read passes ST_LOOK and ST_PREAD, other requests only ST_LOOK, and a write that takes a
// new block also ST_FILL (its 32-word fill sweeps the single pool port), before ST_HOLD loads rsp
// one request is in flight at a time; ST_HOLD takes the next one as it loads the response, if the output is free
// reset: after arst_n releases, a clearing pass writes every one of the tst_pkg::STAGE1_DEPTH (34816)
// stage-1 entries to block 0, one a cycle, with the request channel not ready
`timescale 1ns / 1ps
module two_stage_trie_store_core (
	input  logic      clk,
	input  logic      arst_n,
	tst_req_if.sink   req,
	tst_rsp_if.source rsp
);

	// command and status between controller and datapath
	tst_pkg::cmd_t cmd;
	tst_pkg::sts_t sts;

	// controller: sequences lookups, in-place writes, block allocation and fill,
	// and hands each result to the output register
	tst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: stage-1 block start table, value pool, free-block pointer,
	// the held result and the output register of the response transaction
	tst_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.req_action      (req.action),
		.req_code_point  (req.code_point),
		.req_write_value (req.write_value),
		.rsp_read_value  (rsp.read_value),
		.rsp_pool_full   (rsp.pool_full)
	);

endmodule

// ===== tb/sv/two_stage_trie_store_core_tb.sv =====
// self-checking testbench for the two-stage trie store core
`timescale 1ns / 1ps
module two_stage_trie_store_core_tb;

	// request codes
	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	localparam int RANDOM_ITEMS   = 1200;
	localparam int HOT_SLOTS      = 12;
	localparam int HOT_N          = HOT_SLOTS * 4;
	// the clearing pass after reset holds off requests while it clears every stage-1 entry
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int SETTLE_CYCLES  = 80;

	typedef struct packed {
		logic                             action;
		logic [tst_pkg::CP_W-1:0]         code_point;
		logic signed [tst_pkg::VAL_W-1:0] write_value;
	} lookup_req_t;

	typedef struct packed {
		logic signed [tst_pkg::VAL_W-1:0] read_value;
		logic                             pool_full;
	} lookup_res_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	tst_req_if req_ch ();
	tst_rsp_if rsp_ch ();

	two_stage_trie_store_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// request side, known from time zero
	logic        drv_valid = 1'b0;
	lookup_req_t drv_item  = '0;
	logic        rcv_ready = 1'b0;

	assign req_ch.valid       = drv_valid;
	assign req_ch.action      = drv_item.action;
	assign req_ch.code_point  = drv_item.code_point;
	assign req_ch.write_value = drv_item.write_value;
	assign rsp_ch.ready       = rcv_ready;

	lookup_req_t pending_reqs [$];
	lookup_res_t result_due [$];
	int issued_cnt   = 0;
	int accepted_cnt = 0;
	int error_cnt    = 0;

	// shadow of the trie: stage-1 block starts, the word pool and the allocation pointer
	logic [tst_pkg::PW_AW-1:0] slot_base  [tst_pkg::STAGE1_DEPTH];
	logic [tst_pkg::VAL_W-1:0] word_store [tst_pkg::POOL_WORDS];
	logic [tst_pkg::NF_W-1:0]  alloc_ptr;

	// applies one request to the shadow trie and returns what the core should answer
	function automatic lookup_res_t apply_request(input lookup_req_t r);
		lookup_res_t res;
		int cp_i;
		int slot;
		int ofs;
		int base;
		res.read_value = '0;
		res.pool_full  = 1'b0;
		cp_i = int'(r.code_point);
		slot = cp_i >> tst_pkg::BLOCK_SHIFT;
		ofs  = cp_i & (tst_pkg::BLOCK_WORDS - 1);
		if (r.action == ACT_READ) begin
			// beyond the code space there is no stage-1 entry: fill word
			res.read_value = tst_pkg::FILL_WORD;
			if (cp_i < tst_pkg::CODE_SPAN)
				res.read_value = word_store[int'(slot_base[slot]) + ofs];
		end else if (cp_i < tst_pkg::CODE_SPAN) begin
			base = int'(slot_base[slot]);
			if (base == 0) begin
				if (int'(alloc_ptr) + tst_pkg::BLOCK_WORDS > tst_pkg::POOL_WORDS) begin
					// no block left: transaction dropped, nothing changes
					res.pool_full = 1'b1;
				end else begin
					base = int'(alloc_ptr);
					for (int w = 0; w < tst_pkg::BLOCK_WORDS; w++)
						word_store[base + w] = tst_pkg::FILL_WORD;
					slot_base[slot] = tst_pkg::PW_AW'(base);
					alloc_ptr = alloc_ptr + tst_pkg::NF_W'(tst_pkg::BLOCK_WORDS);
				end
			end
			if (!res.pool_full)
				word_store[base + ofs] = r.write_value;
		end
		return res;
	endfunction

	task automatic queue_request(input logic act, input logic [tst_pkg::CP_W-1:0] cp,
		input logic [tst_pkg::VAL_W-1:0] val);
		lookup_req_t r;
		r.action      = act;
		r.code_point  = cp;
		r.write_value = val;
		pending_reqs.push_back(r);
		issued_cnt++;
	endtask

	task automatic flag_mismatch(input string field, input logic [tst_pkg::VAL_W-1:0] got,
		input logic [tst_pkg::VAL_W-1:0] want);
		$display("[%0t] mismatch on %s: got %h, want %h", $time, field, got, want);
		error_cnt++;
	endtask

	// every issued transaction accepted and answered
	task automatic wait_drained();
		do
			@(posedge clk);
		while (!(accepted_cnt == issued_cnt && result_due.size() == 0));
	endtask

	// driver: bursts of random length separated by random gaps, gaps of zero
	// length give long back-to-back stretches
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid  <= 1'b0;
			burst_left <= 1;
			gap_left   <= 0;
		end else begin
			if (drv_valid && req_ch.ready) begin
				// transaction taken: predict its answer now, in acceptance order
				result_due.push_back(apply_request(drv_item));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!drv_valid || req_ch.ready) begin
				if (gap_left != 0) begin
					gap_left  <= gap_left - 1;
					drv_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					drv_item  <= pending_reqs.pop_front();
					drv_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 48);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: response ready follows the bits of a 32-bit pattern in turn, reloaded with a
	// random density each round (sometimes solid, so no stall at all)
	logic [31:0] stall_pat = '1;
	int          stall_pos = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_ready <= 1'b0;
			stall_pos <= 0;
		end else begin
			if (rsp_ch.valid && rcv_ready) begin
				if (result_due.size() == 0) begin
					flag_mismatch("unexpected transaction", rsp_ch.read_value, '0);
				end else begin
					if (rsp_ch.read_value !== result_due[0].read_value)
						flag_mismatch("read_value", rsp_ch.read_value,
							result_due[0].read_value);
					if (rsp_ch.pool_full !== result_due[0].pool_full)
						flag_mismatch("pool_full", tst_pkg::VAL_W'(rsp_ch.pool_full),
							tst_pkg::VAL_W'(result_due[0].pool_full));
					void'(result_due.pop_front());
				end
			end
			rcv_ready <= stall_pat[stall_pos];
			if (stall_pos == 31) begin
				stall_pos <= 0;
				case ($urandom_range(0, 3))
					0: begin
						stall_pat <= '1;
					end
					1: begin
						stall_pat <= $urandom;
					end
					2: begin
						stall_pat <= $urandom | $urandom;
					end
					default: begin
						stall_pat <= $urandom & $urandom;
					end
				endcase
			end else begin
				stall_pos <= stall_pos + 1;
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] no transaction for %0d cycles", $time, idle_cycles);
			$display("FAIL two_stage_trie_store_core");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int                       n;
		int                       pick;
		int                       free_blocks;
		int                       slot;
		logic [tst_pkg::CP_W-1:0] cp;
		logic [tst_pkg::CP_W-1:0] hot_cp [HOT_N];
		logic [tst_pkg::CP_W-1:0] written [$];

		// shadow trie after reset: every slot on the shared fill block
		for (int s = 0; s < tst_pkg::STAGE1_DEPTH; s++)
			slot_base[s] = '0;
		for (int w = 0; w < tst_pkg::BLOCK_WORDS; w++)
			word_store[w] = tst_pkg::FILL_WORD;
		alloc_ptr = tst_pkg::NF_W'(tst_pkg::BLOCK_WORDS);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, both actions, fill reads, in-place overwrite,
		// code points past the end of the code space
		queue_request(ACT_READ,  21'h000000, 32'h0000_0000);
		queue_request(ACT_WRITE, 21'h000000, 32'h7FFF_FFFF);
		queue_request(ACT_READ,  21'h000000, 32'hFFFF_FFFF);
		queue_request(ACT_READ,  21'h000001, 32'h0000_0000);
		queue_request(ACT_WRITE, 21'h00001F, 32'h8000_0000);
		queue_request(ACT_READ,  21'h00001F, 32'h0000_0000);
		queue_request(ACT_WRITE, 21'h000020, 32'h0000_0000);
		queue_request(ACT_READ,  21'h000020, 32'h0000_0000);
		queue_request(ACT_WRITE, 21'h10FFFF, 32'hFFFF_FFFF);
		queue_request(ACT_READ,  21'h10FFFF, 32'h0000_0000);
		queue_request(ACT_READ,  21'h10FFE0, 32'h0000_0000);
		queue_request(ACT_WRITE, 21'h10FFFF, 32'h0000_0001);
		queue_request(ACT_READ,  21'h10FFFF, 32'h0000_0000);
		queue_request(ACT_WRITE, 21'h100000, 32'hA5A5_5A5A);
		queue_request(ACT_READ,  21'h100000, 32'h0000_0000);
		queue_request(ACT_READ,  21'h0FFFFF, 32'h0000_0000);
		queue_request(ACT_WRITE, 21'h110000, 32'h1234_5678);
		queue_request(ACT_READ,  21'h110000, 32'h0000_0000);
		queue_request(ACT_WRITE, 21'h1FFFFF, 32'hFFFF_FFFF);
		queue_request(ACT_READ,  21'h1FFFFF, 32'hFFFF_FFFF);
		queue_request(ACT_WRITE, 21'h000000, 32'hF000_0000);
		queue_request(ACT_READ,  21'h000000, 32'h0000_0000);
		wait_drained();

		// random: mostly a small hot set so reads land on written words,
		// with scattered reads, allocating writes and out-of-range requests
		for (int h = 0; h < HOT_SLOTS; h++) begin
			if (h == 0)
				slot = 0;
			else if (h == 1)
				slot = tst_pkg::STAGE1_DEPTH - 1;
			else
				slot = $urandom_range(0, tst_pkg::STAGE1_DEPTH - 1);
			hot_cp[4*h]     = tst_pkg::CP_W'(slot * tst_pkg::BLOCK_WORDS);
			hot_cp[4*h + 1] = tst_pkg::CP_W'(slot * tst_pkg::BLOCK_WORDS +
				tst_pkg::BLOCK_WORDS - 1);
			hot_cp[4*h + 2] = tst_pkg::CP_W'(slot * tst_pkg::BLOCK_WORDS +
				$urandom_range(0, tst_pkg::BLOCK_WORDS - 1));
			hot_cp[4*h + 3] = tst_pkg::CP_W'(slot * tst_pkg::BLOCK_WORDS +
				$urandom_range(0, tst_pkg::BLOCK_WORDS - 1));
		end
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 19);
			if (pick < 8)
				queue_request(ACT_WRITE, hot_cp[$urandom_range(0, HOT_N - 1)], $urandom);
			else if (pick < 15)
				queue_request(ACT_READ, hot_cp[$urandom_range(0, HOT_N - 1)], $urandom);
			else if (pick < 17)
				queue_request(ACT_READ,
					tst_pkg::CP_W'($urandom_range(0, tst_pkg::CODE_SPAN - 1)), $urandom);
			else if (pick == 17)
				queue_request(ACT_WRITE,
					tst_pkg::CP_W'($urandom_range(0, tst_pkg::CODE_SPAN - 1)), $urandom);
			else
				queue_request(pick[0] ? ACT_WRITE : ACT_READ,
					tst_pkg::CP_W'($urandom_range(tst_pkg::CODE_SPAN,
					(1 << tst_pkg::CP_W) - 1)), $urandom);
		end
		wait_drained();

		// pool exhaustion: allocate every remaining block, then a few more
		// which must be dropped with pool_full, mixed with reads and
		// in-place overwrites of what was written here
		free_blocks = (tst_pkg::POOL_WORDS - int'(alloc_ptr)) / tst_pkg::BLOCK_WORDS;
		slot = $urandom_range(0, tst_pkg::STAGE1_DEPTH - 1);
		for (n = 0; n < free_blocks + 6; n++) begin
			while (slot_base[slot] != 0)
				slot = (slot + 1) % tst_pkg::STAGE1_DEPTH;
			cp = tst_pkg::CP_W'(slot * tst_pkg::BLOCK_WORDS +
				$urandom_range(0, tst_pkg::BLOCK_WORDS - 1));
			queue_request(ACT_WRITE, cp, $urandom);
			written.push_back(cp);
			slot = (slot + 1) % tst_pkg::STAGE1_DEPTH;
			case ($urandom_range(0, 7))
				0, 1: begin
					queue_request(ACT_READ, written[$urandom_range(0, written.size() - 1)],
						$urandom);
				end
				2: begin
					queue_request(ACT_WRITE, written[$urandom_range(0, written.size() - 1)],
						$urandom);
				end
				default: begin
				end
			endcase
		end
		// pool now full: reads, an in-place write that still lands and a write past the code space
		for (n = 0; n < 20; n++) begin
			queue_request(ACT_READ, written[$urandom_range(0, written.size() - 1)], $urandom);
			queue_request(ACT_READ,
				tst_pkg::CP_W'($urandom_range(0, tst_pkg::CODE_SPAN - 1)), $urandom);
		end
		queue_request(ACT_WRITE, 21'h10FFFF, 32'h8000_0001);
		queue_request(ACT_READ,  21'h10FFFF, 32'h0000_0000);
		queue_request(ACT_WRITE, 21'h1ABCDE, 32'h0BAD_F00D);
		queue_request(ACT_READ,  21'h1ABCDE, 32'h0000_0000);
		wait_drained();

		// room for any stray late transaction to show up
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_cnt == 0)
			$display("PASS two_stage_trie_store_core");
		else
			$display("FAIL two_stage_trie_store_core");
		$finish;
	end

endmodule
